FILE: hw/rtl/ps2mpd_pkg.sv
`timescale 1ns / 1ps

package ps2mpd_pkg;

  // Packet format codes held in the packet_mode register
  localparam logic [1:0] MODE_STD     = 2'd0;
  localparam logic [1:0] MODE_WHEEL   = 2'd1;
  localparam logic [1:0] MODE_BUTTONS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PACKET_MODE = 2'd0;
  localparam logic [1:0] CFG_MAX_X       = 2'd1;
  localparam logic [1:0] CFG_MAX_Y       = 2'd2;

  // Bound reset values
  localparam logic [9:0] MAX_X_RESET = 10'd600;
  localparam logic [9:0] MAX_Y_RESET = 10'd400;

  // First-byte flag positions
  localparam int unsigned BUTTON_LEFT   = 0;
  localparam int unsigned BUTTON_MIDDLE = 2;
  localparam int unsigned SYNC_BIT      = 3;
  localparam int unsigned X_SIGN_BIT    = 4;
  localparam int unsigned Y_SIGN_BIT    = 5;
  localparam int unsigned X_OVF_BIT     = 6;
  localparam int unsigned Y_OVF_BIT     = 7;

  // Queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // One framed packet, as handed from the framer to the cursor unit
  typedef struct packed {
    logic       x_sign;
    logic       y_sign;
    logic [2:0] buttons;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic       wheel_up;
    logic       wheel_down;
  } pkt_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hw/rtl/ps2mpd_framer.sv
`timescale 1ns / 1ps

module ps2mpd_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [1:0]        packet_mode_i,
  output logic              push_o,
  output ps2mpd_pkg::pkt_t  pkt_o
);
  import ps2mpd_pkg::*;

  typedef enum logic [3:0] {
    PH_B0 = 4'b0001,
    PH_B1 = 4'b0010,
    PH_B2 = 4'b0100,
    PH_B3 = 4'b1000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;
  logic [7:0] b2_q, b2_d;
  logic       four_byte;
  logic       last_byte;
  logic       overflow;

  assign four_byte = (packet_mode_i == MODE_WHEEL) || (packet_mode_i == MODE_BUTTONS);

  // Phase tracking and byte capture
  always_comb begin
    phase_d   = phase_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    b2_d      = b2_q;
    last_byte = 1'b0;
    if (accept_i) begin
      case (phase_q)
        PH_B0: begin
          b0_d = rx_byte_i;
          if (rx_byte_i[SYNC_BIT]) begin
            phase_d = PH_B1;
          end
        end
        PH_B1: begin
          b1_d    = rx_byte_i;
          phase_d = PH_B2;
        end
        PH_B2: begin
          b2_d = rx_byte_i;
          if (four_byte) begin
            phase_d = PH_B3;
          end else begin
            phase_d   = PH_B0;
            last_byte = 1'b1;
          end
        end
        PH_B3: begin
          phase_d   = PH_B0;
          last_byte = 1'b1;
        end
        default: begin
          phase_d = PH_B0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_B0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
    b2_q <= b2_d;
  end

  // Packet record; overflowed packets are dropped here
  assign overflow = b0_q[X_OVF_BIT] | b0_q[Y_OVF_BIT];
  assign push_o   = last_byte & ~overflow;

  always_comb begin
    pkt_o.x_sign     = b0_q[X_SIGN_BIT];
    pkt_o.y_sign     = b0_q[Y_SIGN_BIT];
    pkt_o.buttons    = b0_q[BUTTON_MIDDLE:BUTTON_LEFT];
    pkt_o.x_byte     = b1_q;
    pkt_o.y_byte     = (phase_q == PH_B2) ? rx_byte_i : b2_q;
    pkt_o.wheel_up   = 1'b0;
    pkt_o.wheel_down = 1'b0;
    // wheel byte is signed; only read in scroll mode on the fourth byte
    if ((phase_q == PH_B3) && (packet_mode_i == MODE_WHEEL) && (rx_byte_i != 8'd0)) begin
      pkt_o.wheel_up   = rx_byte_i[7];
      pkt_o.wheel_down = ~rx_byte_i[7];
    end
  end

endmodule

FILE: hw/rtl/ps2mpd_queue.sv
`timescale 1ns / 1ps

module ps2mpd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ps2mpd_pkg::pkt_t     push_data_i,
  input  logic                 pop_i,
  output ps2mpd_pkg::pkt_t     pop_data_o,
  output ps2mpd_pkg::q_stat_t  stat_o
);
  import ps2mpd_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  pkt_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/ps2mpd_cursor.sv
`timescale 1ns / 1ps

module ps2mpd_cursor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ps2mpd_pkg::q_stat_t q_stat_i,
  input  ps2mpd_pkg::pkt_t    pkt_i,
  output logic                pop_o,
  input  logic [9:0]          max_x_i,
  input  logic [9:0]          max_y_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [8:0]   delta_x_o,
  output logic signed [9:0]   delta_y_o,
  output logic                left_button_o,
  output logic                right_button_o,
  output logic                middle_button_o,
  output logic                wheel_down_o,
  output logic                wheel_up_o,
  output logic [9:0]          pos_x_o,
  output logic [9:0]          pos_y_o
);
  import ps2mpd_pkg::*;

  logic              valid_q, valid_d;
  logic [9:0]        cur_x_q, cur_x_d;
  logic [9:0]        cur_y_q, cur_y_d;
  logic signed [8:0] dx;
  logic signed [8:0] y_raw;
  logic signed [9:0] dy;
  logic signed [8:0] dx_q;
  logic signed [9:0] dy_q;
  logic [2:0]        buttons_q;
  logic              wheel_up_q;
  logic              wheel_down_q;

  // Add a signed step to the position and clamp to 0..bound
  function automatic logic [9:0] clamp_pos(input logic [9:0] cur, input logic [11:0] step,
                                           input logic [9:0] bound);
    logic [11:0] sum;
    logic [9:0]  res;
    sum = {2'b00, cur} + step;
    if (sum[11]) begin
      res = '0;
    end else if (sum[10:0] > {1'b0, bound}) begin
      res = bound;
    end else begin
      res = sum[9:0];
    end
    return res;
  endfunction

  // Take a packet when the output register is free or being emptied
  assign pop_o = ~q_stat_i.empty & (~valid_q | ~out_stall_i);

  assign dx    = {pkt_i.x_sign, pkt_i.x_byte};
  assign y_raw = {pkt_i.y_sign, pkt_i.y_byte};
  assign dy    = -{y_raw[8], y_raw};

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    valid_d = valid_q & out_stall_i;
    if (pop_o) begin
      cur_x_d = clamp_pos(cur_x_q, {{3{dx[8]}}, dx}, max_x_i);
      cur_y_d = clamp_pos(cur_y_q, {{2{dy[9]}}, dy}, max_y_i);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else begin
      valid_q <= valid_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dx_q         <= dx;
      dy_q         <= dy;
      buttons_q    <= pkt_i.buttons;
      wheel_up_q   <= pkt_i.wheel_up;
      wheel_down_q <= pkt_i.wheel_down;
    end
  end

  assign out_valid_o     = valid_q;
  assign delta_x_o       = dx_q;
  assign delta_y_o       = dy_q;
  assign left_button_o   = buttons_q[0];
  assign right_button_o  = buttons_q[1];
  assign middle_button_o = buttons_q[2];
  assign wheel_down_o    = wheel_down_q;
  assign wheel_up_o      = wheel_up_q;
  assign pos_x_o         = cur_x_q;
  assign pos_y_o         = cur_y_q;

endmodule

FILE: hw/rtl/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps

// PS/2 mouse packet decoder. Takes one received mouse byte per clock while
// in_stall_o is low and frames 3-byte packets (4-byte in scroll-wheel or
// extra-button mode), resyncing on bit 3 of the first byte. Each complete
// packet without X/Y overflow yields one result: 9-bit signed dx, negated
// 10-bit dy (positive is down), three buttons, wheel up/down in scroll mode,
// and the cursor position clamped to 0..max_x and 0..max_y. Overflowed
// packets give no result. A byte is accepted every cycle that in_stall_o is
// low; each finished packet is written into the packet queue and moves on to
// the output register when that register is free. The framer feeds a
// two-entry packet queue, and in_stall_o rises only when that queue is full,
// which happens only when out_stall_i holds back three finished results (one
// in the output register and two in the queue). Configuration writes are
// always ready and take effect at the next cycle.
module ps2_mouse_packet_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [8:0] delta_x_o,
  output logic signed [9:0] delta_y_o,
  output logic              left_button_o,
  output logic              right_button_o,
  output logic              middle_button_o,
  output logic              wheel_down_o,
  output logic              wheel_up_o,
  output logic [9:0]        pos_x_o,
  output logic [9:0]        pos_y_o
);
  import ps2mpd_pkg::*;

  logic       in_accept;
  logic       cfg_write;
  logic [1:0] packet_mode_q;
  logic [9:0] max_x_q;
  logic [9:0] max_y_q;
  logic       push;
  logic       pop;
  pkt_t       push_pkt;
  pkt_t       pop_pkt;
  q_stat_t    q_stat;

  assign in_stall_o  = q_stat.full;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_mode_q <= MODE_STD;
      max_x_q       <= MAX_X_RESET;
      max_y_q       <= MAX_Y_RESET;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_PACKET_MODE: packet_mode_q <= cfg_data_i[1:0];
        CFG_MAX_X:       max_x_q       <= cfg_data_i;
        CFG_MAX_Y:       max_y_q       <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  ps2mpd_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .rx_byte_i     (rx_byte_i),
    .packet_mode_i (packet_mode_q),
    .push_o        (push),
    .pkt_o         (push_pkt)
  );

  ps2mpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_pkt),
    .pop_i       (pop),
    .pop_data_o  (pop_pkt),
    .stat_o      (q_stat)
  );

  ps2mpd_cursor u_cursor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .pkt_i           (pop_pkt),
    .pop_o           (pop),
    .max_x_i         (max_x_q),
    .max_y_i         (max_y_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .delta_x_o       (delta_x_o),
    .delta_y_o       (delta_y_o),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o),
    .middle_button_o (middle_button_o),
    .wheel_down_o    (wheel_down_o),
    .wheel_up_o      (wheel_up_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o)
  );

  // Cursor unit only pops a queue that holds a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty packet queue");

  // Input side is never held off while the queue is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_stat.empty |-> !in_stall_o)
    else $error("input stalled with empty queue");

  // A new result only appears after a packet left the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(pop))
    else $error("result shown without a packet");

  // The queue is never full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule
